// ===== hdl/dvrt_pkg.sv =====
package dvrt_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int MAX_RESULTS     = 32;
   localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0]  METRIC_MAX    = 8'd255;
   localparam logic [15:0] LIFETIME_RST  = 16'd300;

   localparam logic [2:0] OP_ADD_LOCAL = 3'd0;
   localparam logic [2:0] OP_ADVERTISE = 3'd1;
   localparam logic [2:0] OP_PIPE_DOWN = 3'd2;
   localparam logic [2:0] OP_TICK      = 3'd3;
   localparam logic [2:0] OP_LOOKUP    = 3'd4;
   localparam logic [2:0] OP_DUMP      = 3'd5;

   localparam logic [1:0] ST_NO_CHANGE = 2'd0;
   localparam logic [1:0] ST_CHANGED   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic        is_local;
      logic [7:0]  metric;
      logic [31:0] pipe;
      logic        alive;
      logic [31:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== hdl/distance_vector_route_table.sv =====
// Distance-vector route table.
// Request channel (req_*): one operation per transfer, taken when req_valid is
// high and req_stall is low. req_stall stays high from the transfer until the
// operation has placed its final result in the output register.
// Result channel (rsp_*): results sit in an output register, held while
// rsp_stall is high; rsp_last_result marks the final result of an operation.
// Dump yields one result per valid slot (at most 32), or one not-found result
// when no slot is valid; every other operation yields exactly one.
// Sweep: each operation up to dump sweeps the slot memory slot by slot, in the
// states S_RD (address the slot) and S_CK (check the registered read data);
// other operation codes skip the sweep. The single read port of the slot memory
// forces this slot-by-slot order. A stalled receiver during a dump holds the
// sweep at the slot that wants to post a result.
// Configuration (csr_*): csr_wdata sets the dead route lifetime in seconds;
// always ready, write only while the table is idle.
// Reset (synchronous, active high) clears all slot valid bits, the seconds
// counter and the result valid flag, and restores the lifetime to 300.
module distance_vector_route_table #(
   parameter int TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [63:0] req_address_high,
   input  logic [63:0] req_address_low,
   input  logic [7:0]  req_advertised_metric,
   input  logic [31:0] req_pipe_number,
   input  logic        req_advertised_alive,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_route_high,
   output logic [63:0] rsp_route_low,
   output logic [7:0]  rsp_route_metric,
   output logic [31:0] rsp_route_pipe,
   output logic        rsp_route_alive,
   output logic        rsp_route_is_local,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);
   import dvrt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CK   = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_DEND = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   logic [2:0]  op_ff;
   logic [63:0] kh_ff, kl_ff;
   logic [7:0]  m_ff;
   logic [31:0] pipe_ff;
   logic        alive_ff;
   logic [31:0] now_ff, now_in;
   logic [15:0] life_ff;

   logic        hit_ff, hit_in, free_ff, free_in, any_ff, any_in, pend_ff, pend_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   entry_type   ent_ff, ent_in;
   logic [CNT_W-1:0] dcnt_ff, dcnt_in;

   entry_type   rd_ent;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   entry_type   wr_ent;

   logic        emit_en, emit_last;
   logic [1:0]  emit_status;
   entry_type   emit_ent;
   logic        emit_full;

   logic        out_free;
   logic        rsp_valid_ff;
   logic [1:0]  status_ff;
   entry_type   out_ent_ff;
   logic        last_ff, local_ff;

   logic        slot_v, key_eq, last_slot, dead_cond, replace;
   entry_type   new_ent;

   dvrt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (cnt_ff),
      .rd_data (rd_ent)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign slot_v    = valid_ff[cnt_ff];
   assign key_eq    = (rd_ent.key_high == kh_ff) && (rd_ent.key_low == kl_ff);
   assign last_slot = (cnt_ff == AW'(TABLE_DEPTH - 1));

   // Advertise decision on the matched entry.
   assign dead_cond = (m_ff == ent_ff.metric) && (pipe_ff == ent_ff.pipe) &&
                      !alive_ff && ent_ff.alive;
   assign replace   = (m_ff < ent_ff.metric) ||
                      ((ent_ff.pipe == 32'd0) && alive_ff && !dead_cond);

   always_comb begin
      new_ent          = '0;
      new_ent.key_high = kh_ff;
      new_ent.key_low  = kl_ff;
      new_ent.stamp    = now_ff;
      if (op_ff == OP_ADD_LOCAL) begin
         new_ent.is_local = 1'b1;
         new_ent.alive    = 1'b1;
      end else begin
         new_ent.metric = m_ff;
         new_ent.pipe   = pipe_ff;
         new_ent.alive  = alive_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      valid_in    = valid_ff;
      now_in      = now_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      any_in      = any_ff;
      pend_in     = pend_ff;
      ent_in      = ent_ff;
      dcnt_in     = dcnt_ff;
      wr_en       = 1'b0;
      wr_addr     = cnt_ff;
      wr_ent      = rd_ent;
      emit_en     = 1'b0;
      emit_last   = 1'b1;
      emit_status = ST_NO_CHANGE;
      emit_ent    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cnt_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               any_in  = 1'b0;
               pend_in = 1'b0;
               dcnt_in = '0;
               if (req_operation == OP_TICK) begin
                  now_in = now_ff + 32'd1;
               end
               if (req_operation > OP_DUMP) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_CK;
         end
         S_CK: begin
            state_in = last_slot ? ((op_ff == OP_DUMP) ? S_DEND : S_FIN) : S_RD;
            cnt_in   = cnt_ff + AW'(1);
            case (op_ff)
               OP_PIPE_DOWN: begin
                  if (slot_v && rd_ent.pipe == pipe_ff) begin
                     wr_en        = 1'b1;
                     wr_ent.alive = 1'b0;
                     wr_ent.stamp = now_ff;
                     any_in       = 1'b1;
                  end
               end
               OP_TICK: begin
                  if (slot_v && !rd_ent.alive && !hit_ff &&
                      (now_ff - rd_ent.stamp) >= {16'd0, life_ff}) begin
                     hit_in     = 1'b1;
                     hit_idx_in = cnt_ff;
                     ent_in     = rd_ent;
                  end
               end
               OP_DUMP: begin
                  if (slot_v) begin
                     if (pend_ff && !out_free) begin
                        // hold the sweep until the result register drains
                        state_in = S_CK;
                        cnt_in   = cnt_ff;
                     end else begin
                        if (pend_ff) begin
                           emit_en   = 1'b1;
                           emit_last = 1'b0;
                           emit_ent  = ent_ff;
                        end
                        pend_in = 1'b1;
                        ent_in  = rd_ent;
                        dcnt_in = dcnt_ff + CNT_W'(1);
                        if (dcnt_ff == CNT_W'(MAX_RESULTS - 1)) begin
                           state_in = S_DEND;
                        end
                     end
                  end
               end
               default: begin
                  if (slot_v && key_eq && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = cnt_ff;
                     ent_in     = rd_ent;
                  end
                  if (!slot_v && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = cnt_ff;
                  end
               end
            endcase
         end
         S_FIN: begin
            if (out_free) begin
               emit_en  = 1'b1;
               state_in = S_IDLE;
               case (op_ff) inside
                  OP_ADD_LOCAL, OP_ADVERTISE: begin
                     if (hit_ff) begin
                        emit_ent = ent_ff;
                        if (op_ff == OP_ADVERTISE && !ent_ff.is_local) begin
                           if (replace) begin
                              emit_ent = new_ent;
                           end else if (dead_cond) begin
                              emit_ent.alive = 1'b0;
                              emit_ent.stamp = now_ff;
                           end
                           if (replace || dead_cond) begin
                              wr_en       = 1'b1;
                              wr_addr     = hit_idx_ff;
                              wr_ent      = emit_ent;
                              emit_status = ST_CHANGED;
                           end
                        end
                     end else if (free_ff) begin
                        wr_en                 = 1'b1;
                        wr_addr               = free_idx_ff;
                        wr_ent                = new_ent;
                        valid_in[free_idx_ff] = 1'b1;
                        emit_ent              = new_ent;
                        emit_status           = ST_CHANGED;
                     end else begin
                        emit_ent.key_high = kh_ff;
                        emit_ent.key_low  = kl_ff;
                        emit_status       = ST_FULL;
                     end
                  end
                  OP_PIPE_DOWN: begin
                     emit_status = any_ff ? ST_CHANGED : ST_NO_CHANGE;
                  end
                  OP_TICK: begin
                     if (hit_ff) begin
                        emit_ent             = ent_ff;
                        emit_status          = ST_CHANGED;
                        valid_in[hit_idx_ff] = 1'b0;
                     end
                  end
                  OP_LOOKUP: begin
                     if (hit_ff) begin
                        emit_ent = ent_ff;
                     end else begin
                        emit_status = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     emit_status = ST_NO_CHANGE;
                  end
               endcase
            end
         end
         S_DEND: begin
            if (out_free) begin
               emit_en  = 1'b1;
               state_in = S_IDLE;
               pend_in  = 1'b0;
               if (pend_ff) begin
                  emit_ent = ent_ff;
               end else begin
                  emit_status = ST_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Blank results carry no metric, pipe or marks.
   assign emit_full = (state_ff == S_CK) || (emit_status != ST_FULL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         now_ff       <= '0;
         life_ff      <= LIFETIME_RST;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         any_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         now_ff   <= now_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
         any_ff   <= any_in;
         pend_ff  <= pend_in;
         dcnt_ff  <= dcnt_in;
         if (csr_valid) begin
            life_ff <= csr_wdata;
         end
         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      ent_ff      <= ent_in;
      if (state_ff == S_IDLE && req_valid) begin
         op_ff    <= req_operation;
         kh_ff    <= req_address_high;
         kl_ff    <= req_address_low;
         m_ff     <= (req_advertised_metric < METRIC_MAX) ?
                     req_advertised_metric + 8'd1 : METRIC_MAX;
         pipe_ff  <= req_pipe_number;
         alive_ff <= req_advertised_alive;
      end
      if (emit_en) begin
         status_ff  <= emit_status;
         out_ent_ff <= emit_ent;
         local_ff   <= emit_ent.is_local & emit_full;
         last_ff    <= emit_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_route_high     = out_ent_ff.key_high;
   assign rsp_route_low      = out_ent_ff.key_low;
   assign rsp_route_metric   = out_ent_ff.metric;
   assign rsp_route_pipe     = out_ent_ff.pipe;
   assign rsp_route_alive    = out_ent_ff.alive;
   assign rsp_route_is_local = local_ff;
   assign rsp_last_result    = last_ff;

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(status_ff) && $stable(last_ff))
      else $error("result changed while stalled");

   a_dump_cap: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("dump count beyond result limit");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_ff)
      else $error("pending dump entry left in idle");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_en |-> out_free)
      else $error("result posted over an unsent result");

endmodule

// ===== hdl/dvrt_ram.sv =====
module dvrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
